FILE: rtl/grp_pkg.sv
package grp_pkg;

    // Fixed field widths of the request, response and register beats
    localparam int REQ_W     = 13;
    localparam int CH_W      = 3;
    localparam int OUT_W     = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] ATLAS_DIM_RESET = 13'd4096;
    localparam logic [CH_W-1:0]  ATLAS_CH_RESET  = 3'd4;

    typedef enum logic [0:0] {
        OP_PLACE = 1'b0,
        OP_INIT  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_CHAN   = 2'd1,
        STS_NOFIT  = 2'd2,
        STS_FULL   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_W  = 2'd0,
        CFG_ATLAS_H  = 2'd1,
        CFG_ATLAS_CH = 2'd2
    } cfg_idx_t;

    // Outcome of testing one free rectangle against the request
    typedef struct packed {
        logic fit;
        logic exact;
        logic eq_w;
        logic eq_h;
    } cut_flags_t;

endpackage

FILE: rtl/grp_if.sv
interface grp_req_if
    import grp_pkg::*;
();
    logic             valid;
    logic             ready;
    op_t              op;
    logic [REQ_W-1:0] req_width;
    logic [REQ_W-1:0] req_height;
    logic [CH_W-1:0]  req_channels;

    modport source (output valid, op, req_width, req_height, req_channels, input ready);
    modport sink   (input valid, op, req_width, req_height, req_channels, output ready);
endinterface

interface grp_rsp_if
    import grp_pkg::*;
();
    logic             valid;
    logic             ready;
    status_t          status;
    logic [OUT_W-1:0] place_x;
    logic [OUT_W-1:0] place_y;

    modport source (output valid, status, place_x, place_y, input ready);
    modport sink   (input valid, status, place_x, place_y, output ready);
endinterface

interface grp_cfg_if
    import grp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REQ_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/grp_ram.sv
module grp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/grp_alu.sv
module grp_alu
    import grp_pkg::*;
#(
    parameter int DIM_W = 13
) (
    input  logic [4*DIM_W-1:0] ent,
    input  logic [REQ_W-1:0]   rw,
    input  logic [REQ_W-1:0]   rh,
    output cut_flags_t         flags,
    output logic [4*DIM_W-1:0] ent_upd,
    output logic [4*DIM_W-1:0] ent_app
);

    localparam int CMP_W = (DIM_W > REQ_W) ? DIM_W : REQ_W;

    logic [DIM_W-1:0] x, y, w, h;
    logic [CMP_W-1:0] x_e, y_e, w_e, h_e, rw_e, rh_e;
    logic [CMP_W-1:0] x_sum, y_sum, w_dif, h_dif;

    assign {x, y, w, h} = ent;
    assign x_e  = CMP_W'(x);
    assign y_e  = CMP_W'(y);
    assign w_e  = CMP_W'(w);
    assign h_e  = CMP_W'(h);
    assign rw_e = CMP_W'(rw);
    assign rh_e = CMP_W'(rh);

    assign flags.fit   = (rw_e <= w_e) && (rh_e <= h_e);
    assign flags.eq_w  = (rw_e == w_e);
    assign flags.eq_h  = (rh_e == h_e);
    assign flags.exact = flags.eq_w && flags.eq_h;

    // Sums stay in range once the request fits
    assign x_sum = x_e + rw_e;
    assign y_sum = y_e + rh_e;
    assign w_dif = w_e - rw_e;
    assign h_dif = h_e - rh_e;

    // Equal width keeps the part below, otherwise keep the part to the right
    assign ent_upd = flags.eq_w ?
        {x, y_sum[DIM_W-1:0], w, h_dif[DIM_W-1:0]} :
        {x_sum[DIM_W-1:0], y, w_dif[DIM_W-1:0], h};

    assign ent_app = {x, y_sum[DIM_W-1:0], rw_e[DIM_W-1:0], h_dif[DIM_W-1:0]};

endmodule

FILE: rtl/guillotine_rect_packer_core.sv
// Sequence: a reinit or refusal goes from accept straight to S_OUT; a placement reads
//   and tests table entries (S_RD, S_CMP) up to the first fit, then closes up the table
//   after an exact fit (S_MVRD, S_MVWR per entry moved) or appends a split (S_APP).
//   S_OUT waits while a beat is still held in the output register.
// One request at a time: the next is taken only once the last result has left S_OUT; the
//   table scan runs through the shared cut unit. Reset: table holds one whole-atlas rectangle
//   (min(4096, MAX_DIM) square), registers at 4096 x 4096 x 4 channels; no clearing pass.
module guillotine_rect_packer_core
    import grp_pkg::*;
#(
    parameter int MAX_RECTS = 64,
    parameter int MAX_DIM   = 4096
) (
    input  logic      clk,
    input  logic      rst_n,
    grp_req_if.sink   req,
    grp_rsp_if.source rsp,
    grp_cfg_if.sink   cfg
);

    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int ENT_W    = 4 * DIM_W;
    localparam int ADDR_W   = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W    = $clog2(MAX_RECTS + 1);
    localparam int INIT_DIM = (MAX_DIM < 4096) ? MAX_DIM : 4096;

    localparam logic [ENT_W-1:0] FRESH_ENT =
        {DIM_W'(0), DIM_W'(0), DIM_W'(INIT_DIM), DIM_W'(INIT_DIM)};

    // Sequencer: scan reads an entry then tests it; close-up reads i+1 then writes i
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_APP  = 7'b0001000,
        S_MVRD = 7'b0010000,
        S_MVWR = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    // Entry 0 still holds its reset value and has not been written to RAM
    logic             fresh_reg, fresh_next;

    logic [REQ_W-1:0] atlas_w_reg, atlas_w_next;
    logic [REQ_W-1:0] atlas_h_reg, atlas_h_next;
    logic [CH_W-1:0]  atlas_ch_reg, atlas_ch_next;

    // Request payload and pending append entry
    logic [REQ_W-1:0] rw_reg, rw_next;
    logic [REQ_W-1:0] rh_reg, rh_next;
    logic [ENT_W-1:0] app_reg, app_next;

    status_t          res_status_reg, res_status_next;
    logic [OUT_W-1:0] res_x_reg, res_x_next;
    logic [OUT_W-1:0] res_y_reg, res_y_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [OUT_W-1:0] out_x_reg, out_x_next;
    logic [OUT_W-1:0] out_y_reg, out_y_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENT_W-1:0]  ram_wdata, ram_rdata;

    logic [ENT_W-1:0] ent_cur, ent_upd, ent_app;
    cut_flags_t       flags;
    logic [DIM_W-1:0] atlas_w_lim, atlas_h_lim;
    logic [CNT_W-1:0] idx_inc, cnt_dec;
    logic [31:0]      ent_x32, ent_y32;
    logic             slot_free;

    grp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_cur = (idx_reg == '0 && fresh_reg) ? FRESH_ENT : ram_rdata;

    grp_alu #(
        .DIM_W (DIM_W)
    ) u_alu (
        .ent     (ent_cur),
        .rw      (rw_reg),
        .rh      (rh_reg),
        .flags   (flags),
        .ent_upd (ent_upd),
        .ent_app (ent_app)
    );

    // Atlas size is clamped to MAX_DIM on reinit
    assign atlas_w_lim = (32'(atlas_w_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(atlas_w_reg);
    assign atlas_h_lim = (32'(atlas_h_reg) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(atlas_h_reg);

    assign idx_inc = idx_reg + CNT_W'(1);
    assign cnt_dec = count_reg - CNT_W'(1);
    assign ent_x32 = 32'(ent_cur[4*DIM_W-1 -: DIM_W]);
    assign ent_y32 = 32'(ent_cur[3*DIM_W-1 -: DIM_W]);

    assign slot_free = !out_valid_reg || rsp.ready;

    assign req.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.place_x = out_x_reg;
    assign rsp.place_y = out_y_reg;

    // Register writes
    always_comb
    begin
        atlas_w_next  = atlas_w_reg;
        atlas_h_next  = atlas_h_reg;
        atlas_ch_next = atlas_ch_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ATLAS_W:  atlas_w_next  = cfg.data;
                CFG_ATLAS_H:  atlas_h_next  = cfg.data;
                CFG_ATLAS_CH: atlas_ch_next = cfg.data[CH_W-1:0];
                default:      ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        rw_next         = rw_reg;
        rh_next         = rh_reg;
        app_next        = app_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg[ADDR_W-1:0];
        ram_wdata       = ent_upd;
        ram_raddr       = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rw_next    = req.req_width;
                    rh_next    = req.req_height;
                    res_x_next = '0;
                    res_y_next = '0;
                    idx_next   = '0;
                    state_next = S_OUT;
                    priority if (req.op == OP_INIT)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = '0;
                        ram_wdata       = {DIM_W'(0), DIM_W'(0), atlas_w_lim, atlas_h_lim};
                        count_next      = CNT_W'(1);
                        fresh_next      = 1'b0;
                        res_status_next = STS_OK;
                    end
                    else if (req.req_channels != atlas_ch_reg)
                    begin
                        res_status_next = STS_CHAN;
                    end
                    else if (req.req_width == '0 || req.req_height == '0 || count_reg == '0)
                    begin
                        res_status_next = STS_NOFIT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!flags.fit)
                begin
                    if (idx_inc < count_reg)
                    begin
                        idx_next   = idx_inc;
                        state_next = S_RD;
                    end
                    else
                    begin
                        res_status_next = STS_NOFIT;
                        state_next      = S_OUT;
                    end
                end
                else
                begin
                    res_status_next = STS_OK;
                    res_x_next      = ent_x32[OUT_W-1:0];
                    res_y_next      = ent_y32[OUT_W-1:0];
                    state_next      = S_OUT;
                    priority if (flags.exact)
                    begin
                        fresh_next = 1'b0;
                        if (idx_inc < count_reg)
                        begin
                            state_next = S_MVRD;
                        end
                        else
                        begin
                            count_next = cnt_dec;
                        end
                    end
                    else if (flags.eq_w || flags.eq_h)
                    begin
                        ram_we     = 1'b1;
                        fresh_next = 1'b0;
                    end
                    else if (32'(count_reg) >= 32'(MAX_RECTS))
                    begin
                        // split needs a new entry and the table is full
                        res_status_next = STS_FULL;
                        res_x_next      = '0;
                        res_y_next      = '0;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        fresh_next = 1'b0;
                        app_next   = ent_app;
                        state_next = S_APP;
                    end
                end
            end
            S_APP:
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[ADDR_W-1:0];
                ram_wdata  = app_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_OUT;
            end
            S_MVRD:
            begin
                ram_raddr  = idx_inc[ADDR_W-1:0];
                state_next = S_MVWR;
            end
            S_MVWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (idx_inc < cnt_dec)
                begin
                    idx_next   = idx_inc;
                    state_next = S_MVRD;
                end
                else
                begin
                    count_next = cnt_dec;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= CNT_W'(1);
            fresh_reg     <= 1'b1;
            atlas_w_reg   <= ATLAS_DIM_RESET;
            atlas_h_reg   <= ATLAS_DIM_RESET;
            atlas_ch_reg  <= ATLAS_CH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            atlas_w_reg   <= atlas_w_next;
            atlas_h_reg   <= atlas_h_next;
            atlas_ch_reg  <= atlas_ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rw_reg         <= rw_next;
        rh_reg         <= rh_next;
        app_reg        <= app_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        out_status_reg <= out_status_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
    end

    // Fill count never runs past the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(MAX_RECTS))
        else $error("free count exceeds table depth");

    // Reinit leaves exactly one rectangle, held in RAM
    a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_INIT) |=> (count_reg == CNT_W'(1) && !fresh_reg))
        else $error("reinit did not rebuild the table");

    // Append only happens with room left
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APP) |-> (32'(count_reg) < 32'(MAX_RECTS)))
        else $error("append into a full table");

    // One request in flight: busy right after accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while busy");

endmodule
